>>> rtl/iffp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 flow header parser.
// Used by every module of the block; depends on nothing.
package iffp_pkg;

    // Default depth of the queue between the capture front and the judge back.
    localparam int QUEUE_DEPTH_DEF = 2;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 176;

    // Ethertype as captured (byte 12 low, byte 13 high), so IPv4 reads 0x0008.
    localparam logic [15:0] ETHERTYPE_IPV4_LE = 16'h0008;

    // IP protocol numbers that produce a flow record.
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_SCTP = 8'd132;

    // Frame offsets of the captured header fields.
    localparam logic [15:0] POS_ETYPE_LO  = 16'd12;
    localparam logic [15:0] POS_ETYPE_HI  = 16'd13;
    localparam logic [15:0] POS_IHL       = 16'd14;
    localparam logic [15:0] POS_PROTO     = 16'd23;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;

    // Length limits.
    localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [15:0] MIN_IPV4_FRAME = 16'd34;
    localparam logic [6:0]  L4_BASE        = 7'd14;
    localparam logic [6:0]  TCP_HDR_LEN    = 7'd20;
    localparam logic [6:0]  UDP_HDR_LEN    = 7'd8;
    localparam logic [6:0]  SCTP_HDR_LEN   = 7'd12;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Everything captured from one frame, handed from the front to the back.
    typedef struct packed {
        logic [15:0] frame_len;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [7:0]  protocol;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [63:0] stamp_ns;
    } snap_t;

    // Port offset L = 14 + 4 * IHL.
    function automatic logic [6:0] l4_offset(input logic [3:0] ihl);
        l4_offset = L4_BASE + {1'b0, ihl, 2'b00};
    endfunction

endpackage

>>> rtl/ipv4_flow_header_parser.sv
`timescale 1ns / 1ps
// Top level of the IPv4 flow header parser: capture front, snapshot queue, judge back.
// Depends on iffp_pkg, iffp_front, iffp_queue and iffp_back.
//
//  Channel   Dir  Transfer                 Payload
//  s_axis    in   one frame byte           tdata: frame_byte, now_ns; tlast: frame_end
//  m_axis    out  one verdict per frame    tdata: verdict .. stamp_ns (see port list)
//
// One frame byte is taken every cycle while the queue has room; a verdict per cycle
// can be sustained while m_axis is ready. A final byte's verdict passes through the
// snapshot queue, then the output register. Reset clears the per-frame capture
// state, the queue and the output valid at once. s_axis_tready drops only while the
// queue is full, which happens when m_axis stalls with QUEUE_DEPTH verdicts
// waiting behind the one in the output register.
module ipv4_flow_header_parser
    import iffp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] frame_byte, [71:8] now_ns
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] verdict, [1] record_valid, [33:2] dest_addr, [49:34] dest_port,
    // [57:50] ip_protocol, [89:58] source_addr, [105:90] source_port,
    // [169:106] stamp_ns, [175:170] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic  push;
    snap_t push_snap;
    logic  pop;
    logic  queue_full;
    logic  queue_not_empty;
    snap_t head_snap;

    iffp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_ready (s_axis_tready),
        .frame_byte (s_axis_tdata[7:0]),
        .frame_end  (s_axis_tlast),
        .now_ns     (s_axis_tdata[71:8]),
        .queue_full (queue_full),
        .push       (push),
        .push_snap  (push_snap)
    );

    iffp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_snap (push_snap),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_snap (head_snap)
    );

    iffp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .snap_valid (queue_not_empty),
        .snap       (head_snap),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

>>> rtl/iffp_front.sv
`timescale 1ns / 1ps
// Capture front: counts frame bytes and picks the header fields off the stream.
// On the final byte it pushes a frame snapshot into the queue. Uses iffp_pkg.
module iffp_front
    import iffp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  frame_byte,
    input  logic        frame_end,
    input  logic [63:0] now_ns,
    input  logic        queue_full,
    output logic        push,
    output snap_t       push_snap
);

    logic [15:0] count_reg,     count_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [3:0]  ihl_reg,       ihl_next;
    logic [7:0]  proto_reg,     proto_next;
    logic [31:0] src_reg,       src_next;
    logic [31:0] dst_reg,       dst_next;
    logic [15:0] sport_reg,     sport_next;
    logic [15:0] dport_reg,     dport_next;
    logic [15:0] l4_pos;
    logic        accept;

    // A byte is taken whenever the queue has room for a possible verdict.
    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    // Field capture for the byte at the current position.
    always_comb
    begin
        count_next     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 16'd1;
        ethertype_next = ethertype_reg;
        ihl_next       = ihl_reg;
        proto_next     = proto_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        sport_next     = sport_reg;
        dport_next     = dport_reg;

        if (count_reg == POS_ETYPE_LO)
        begin
            ethertype_next = {ethertype_reg[15:8], frame_byte};
        end
        if (count_reg == POS_ETYPE_HI)
        begin
            ethertype_next = {frame_byte, ethertype_reg[7:0]};
        end
        if (count_reg == POS_IHL)
        begin
            ihl_next = frame_byte[3:0];
        end
        if (count_reg == POS_PROTO)
        begin
            proto_next = frame_byte;
        end
        if (count_reg >= POS_SRC_FIRST && count_reg <= POS_SRC_LAST)
        begin
            src_next = {src_reg[23:0], frame_byte};
        end
        if (count_reg >= POS_DST_FIRST && count_reg <= POS_DST_LAST)
        begin
            dst_next = {dst_reg[23:0], frame_byte};
        end

        // The port offset already sees an IHL captured on this very byte.
        l4_pos = {9'b0, l4_offset(ihl_next)};
        if (count_reg >= ETH_HDR_LEN)
        begin
            if (count_reg == l4_pos || count_reg == l4_pos + 16'd1)
            begin
                sport_next = {sport_reg[7:0], frame_byte};
            end
            if (count_reg == l4_pos + 16'd2 || count_reg == l4_pos + 16'd3)
            begin
                dport_next = {dport_reg[7:0], frame_byte};
            end
        end
    end

    // Snapshot of the frame as it stands after the final byte.
    assign push = accept && frame_end;
    always_comb
    begin
        push_snap.frame_len   = count_next;
        push_snap.ethertype   = ethertype_next;
        push_snap.ihl         = ihl_next;
        push_snap.protocol    = proto_next;
        push_snap.source_addr = src_next;
        push_snap.dest_addr   = dst_next;
        push_snap.source_port = sport_next;
        push_snap.dest_port   = dport_next;
        push_snap.stamp_ns    = now_ns;
    end

    // Per-frame state; cleared after the final byte so the next frame starts fresh.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ethertype_reg <= '0;
            ihl_reg       <= '0;
            proto_reg     <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            sport_reg     <= '0;
            dport_reg     <= '0;
        end
        else if (accept)
        begin
            if (frame_end)
            begin
                count_reg     <= '0;
                ethertype_reg <= '0;
                ihl_reg       <= '0;
                proto_reg     <= '0;
                src_reg       <= '0;
                dst_reg       <= '0;
                sport_reg     <= '0;
                dport_reg     <= '0;
            end
            else
            begin
                count_reg     <= count_next;
                ethertype_reg <= ethertype_next;
                ihl_reg       <= ihl_next;
                proto_reg     <= proto_next;
                src_reg       <= src_next;
                dst_reg       <= dst_next;
                sport_reg     <= sport_next;
                dport_reg     <= dport_next;
            end
        end
    end

endmodule

>>> rtl/iffp_queue.sv
`timescale 1ns / 1ps
// Small register queue of frame snapshots between the capture front and the back.
// Uses snap_t from iffp_pkg.
module iffp_queue
    import iffp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  snap_t push_snap,
    input  logic  pop,
    output logic  full,
    output logic  not_empty,
    output snap_t head_snap
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    snap_t             entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_snap = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Snapshot storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_snap;
        end
    end

    // Occupancy never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue occupancy above depth");

    // The back only takes a snapshot that is there.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue popped while empty");

    // The front never writes over a waiting snapshot.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

endmodule

>>> rtl/iffp_back.sv
`timescale 1ns / 1ps
// Judge back: takes a frame snapshot, forms the verdict and the flow record,
// and holds the result in an output register. Uses iffp_pkg.
module iffp_back
    import iffp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   snap_valid,
    input  snap_t                  snap,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_TDATA_W-1:0] out_data
);

    logic                   valid_reg;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [6:0]             l4;
    logic [6:0]             need;
    logic                   known;
    logic                   pass;
    logic                   rec;

    // Needed length for the layer four header of each known protocol.
    always_comb
    begin
        l4    = l4_offset(snap.ihl);
        need  = l4;
        known = 1'b0;
        case (snap.protocol)
            PROTO_TCP:
            begin
                need  = l4 + TCP_HDR_LEN;
                known = 1'b1;
            end
            PROTO_UDP:
            begin
                need  = l4 + UDP_HDR_LEN;
                known = 1'b1;
            end
            PROTO_SCTP:
            begin
                need  = l4 + SCTP_HDR_LEN;
                known = 1'b1;
            end
            default:
            begin
                need  = l4;
                known = 1'b0;
            end
        endcase
    end

    // Verdict: runts drop, non-IPv4 passes, IPv4 needs full headers and a known protocol.
    always_comb
    begin
        pass = 1'b0;
        rec  = 1'b0;
        if (snap.frame_len < ETH_HDR_LEN)
        begin
            pass = 1'b0;
        end
        else if (snap.ethertype != ETHERTYPE_IPV4_LE)
        begin
            pass = 1'b1;
        end
        else if (snap.frame_len < MIN_IPV4_FRAME)
        begin
            pass = 1'b0;
        end
        else if (known && snap.frame_len >= {9'b0, need})
        begin
            pass = 1'b1;
            rec  = 1'b1;
        end
    end

    // Result packing; record fields are zero unless a record is given.
    always_comb
    begin
        data_next = '0;
        data_next[0] = pass;
        data_next[1] = rec;
        if (rec)
        begin
            data_next[33:2]    = snap.dest_addr;
            data_next[49:34]   = snap.dest_port;
            data_next[57:50]   = snap.protocol;
            data_next[89:58]   = snap.source_addr;
            data_next[105:90]  = snap.source_port;
            data_next[169:106] = snap.stamp_ns;
        end
    end

    // Output register loads whenever it is empty or being drained.
    assign pop       = snap_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!valid_reg || out_ready)
        begin
            valid_reg <= snap_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
        end
    end

    // A flow record only comes with a pass verdict.
    a_rec_pass: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data[1] |-> out_data[0])
        else $error("flow record on a dropped frame");

    // Without a record every record field reads zero.
    a_norec_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data[1] |-> (out_data[OUT_TDATA_W-1:2] == '0))
        else $error("record fields set without a record");

endmodule

>>> tb/ipv4_flow_header_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for ipv4_flow_header_parser: frames go in one byte per
// transfer, verdicts are checked against a cycle-free model of the header capture.
// Depends on iffp_pkg and the ipv4_flow_header_parser RTL.
module ipv4_flow_header_parser_tb;
    import iffp_pkg::*;

    localparam int RANDOM_ITEMS = 980;
    localparam int LONG_HOLD    = 800;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 2500000;
    localparam int REPORT_MAX   = 10;

    // How a generated frame fills its ethertype bytes.
    typedef enum int {
        KIND_OTHER,
        KIND_IPV4,
        KIND_SWAPPED
    } frame_kind_e;

    // Receiver stall patterns.
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_e;

    typedef struct {
        logic [7:0]  frame_byte;
        logic        frame_end;
        logic [63:0] now_ns;
    } frame_item_t;

    typedef struct {
        logic        verdict;
        logic        record_valid;
        logic [31:0] dest_addr;
        logic [15:0] dest_port;
        logic [7:0]  ip_protocol;
        logic [31:0] source_addr;
        logic [15:0] source_port;
        logic [63:0] stamp_ns;
    } flow_verdict_t;

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    frame_item_t   bytes_pending[$];
    flow_verdict_t verdicts_due[$];
    int            fail_count = 0;
    int            cycle_count = 0;
    logic          hold_request = 1'b0;

    // Model of the per-frame capture registers.
    logic [15:0] frame_pos;
    logic [15:0] etype_cap;
    logic [3:0]  ihl_cap;
    logic [7:0]  proto_cap;
    logic [31:0] src_addr_cap;
    logic [31:0] dst_addr_cap;
    logic [15:0] src_port_cap;
    logic [15:0] dst_port_cap;

    ipv4_flow_header_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic clear_capture();
        frame_pos    = '0;
        etype_cap    = '0;
        ihl_cap      = '0;
        proto_cap    = '0;
        src_addr_cap = '0;
        dst_addr_cap = '0;
        src_port_cap = '0;
        dst_port_cap = '0;
    endtask

    // Advance the capture model by one accepted frame byte; on the final byte
    // judge the frame and queue the verdict it must produce.
    task automatic take_frame_byte(input logic [7:0] b, input logic last,
                                   input logic [63:0] stamp);
        int            pos;
        int            port_at;
        int            len;
        int            need;
        flow_verdict_t v;
        pos = int'(frame_pos);
        if (frame_pos != COUNT_MAX)
            frame_pos = frame_pos + 16'd1;
        if (pos == POS_ETYPE_LO)
            etype_cap[7:0] = b;
        if (pos == POS_ETYPE_HI)
            etype_cap[15:8] = b;
        if (pos == POS_IHL)
            ihl_cap = b[3:0];
        if (pos == POS_PROTO)
            proto_cap = b;
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            src_addr_cap = {src_addr_cap[23:0], b};
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
            dst_addr_cap = {dst_addr_cap[23:0], b};
        // The port offset follows the IHL already updated by this byte.
        port_at = ETH_HDR_LEN + 4 * ihl_cap;
        if (pos >= ETH_HDR_LEN) begin
            if (pos == port_at || pos == port_at + 1)
                src_port_cap = {src_port_cap[7:0], b};
            if (pos == port_at + 2 || pos == port_at + 3)
                dst_port_cap = {dst_port_cap[7:0], b};
        end
        if (!last)
            return;

        len = int'(frame_pos);
        v = '{default: '0};
        if (len < ETH_HDR_LEN)
            v.verdict = 1'b0;
        else if (etype_cap != ETHERTYPE_IPV4_LE)
            v.verdict = 1'b1;
        else if (len >= MIN_IPV4_FRAME) begin
            need = 0;
            if (proto_cap == PROTO_TCP)
                need = port_at + TCP_HDR_LEN;
            else if (proto_cap == PROTO_UDP)
                need = port_at + UDP_HDR_LEN;
            else if (proto_cap == PROTO_SCTP)
                need = port_at + SCTP_HDR_LEN;
            if (need != 0 && len >= need) begin
                v.verdict      = 1'b1;
                v.record_valid = 1'b1;
                v.dest_addr    = dst_addr_cap;
                v.dest_port    = dst_port_cap;
                v.ip_protocol  = proto_cap;
                v.source_addr  = src_addr_cap;
                v.source_port  = src_port_cap;
                v.stamp_ns     = stamp;
            end
        end
        verdicts_due.push_back(v);
        clear_capture();
    endtask

    // Append one frame of len bytes to the send queue.
    task automatic queue_frame(input int len, input frame_kind_e kind, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [63:0] stamp);
        frame_item_t item;
        logic [7:0]  b;
        logic [7:0]  etype_lo;
        etype_lo = 8'h00;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            case (kind)
                KIND_IPV4:
                begin
                    if (i == 12)
                        b = 8'h08;
                    else if (i == 13)
                        b = 8'h00;
                    else if (i == 14)
                        b = {b[7:4], ihl};
                    else if (i == 23)
                        b = proto;
                end
                KIND_SWAPPED:
                begin
                    if (i == 12)
                        b = 8'h00;
                    else if (i == 13)
                        b = 8'h08;
                end
                default:
                begin
                    // Keep the ethertype away from IPv4.
                    if (i == 12)
                        etype_lo = b;
                    else if (i == 13 && etype_lo == 8'h08 && b == 8'h00)
                        b = 8'h01;
                end
            endcase
            item.frame_byte = b;
            item.frame_end  = (i == len - 1);
            item.now_ns     = (i == len - 1) ? stamp : rand64();
            bytes_pending.push_back(item);
        end
    endtask

    // Block until every queued byte is sent and every verdict has arrived.
    task automatic wait_drained();
        while (bytes_pending.size() != 0 || s_axis_tvalid || verdicts_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("verdict mismatch in %s: expected %h, got %h", name, want, got);
        end
    endtask

    // Driver: bursts of transfers with random gaps, fed from bytes_pending.
    int          burst_left;
    int          gap_left;
    frame_item_t next_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            burst_left    <= 0;
            gap_left      <= 0;
            clear_capture();
        end
        else begin
            if (s_axis_tvalid && s_axis_tready)
                take_frame_byte(s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[71:8]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left      <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (bytes_pending.size() != 0) begin
                    next_item     = bytes_pending.pop_front();
                    s_axis_tdata  <= {next_item.now_ns, next_item.frame_byte};
                    s_axis_tlast  <= next_item.frame_end;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 64);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: a changing stall pattern, plus one long hold on request.
    rx_mode_e rx_mode;
    int       rx_mode_left;
    int       hold_left;
    logic     hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            rx_mode       <= RX_OPEN;
            rx_mode_left  <= 0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (hold_request && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= rx_mode_e'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(20, 200);
            end
            else
                rx_mode_left <= rx_mode_left - 1;
            case (rx_mode)
                RX_OPEN:   m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // Monitor: compare each verdict transfer with the oldest expected one.
    flow_verdict_t want_v;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdicts_due.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected verdict transfer: %h", m_axis_tdata);
            end
            else begin
                want_v = verdicts_due.pop_front();
                check_field("verdict", 64'(want_v.verdict), 64'(m_axis_tdata[0]));
                check_field("record_valid", 64'(want_v.record_valid),
                            64'(m_axis_tdata[1]));
                check_field("dest_addr", 64'(want_v.dest_addr), 64'(m_axis_tdata[33:2]));
                check_field("dest_port", 64'(want_v.dest_port), 64'(m_axis_tdata[49:34]));
                check_field("ip_protocol", 64'(want_v.ip_protocol),
                            64'(m_axis_tdata[57:50]));
                check_field("source_addr", 64'(want_v.source_addr),
                            64'(m_axis_tdata[89:58]));
                check_field("source_port", 64'(want_v.source_port),
                            64'(m_axis_tdata[105:90]));
                check_field("stamp_ns", want_v.stamp_ns, m_axis_tdata[169:106]);
            end
        end
    end

    // Watchdog on total run length.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus sequence.
    initial
    begin
        int          len;
        int          need;
        int          hdr;
        int          random_bytes;
        int          pick;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        frame_kind_e kind;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed frames: length limits, each protocol at its threshold, odd IHL values.
        queue_frame(1, KIND_OTHER, 4'd5, PROTO_TCP, 64'd0);
        queue_frame(13, KIND_OTHER, 4'd5, PROTO_TCP, '1);
        queue_frame(14, KIND_OTHER, 4'd5, PROTO_TCP, rand64());
        queue_frame(14, KIND_IPV4, 4'd5, PROTO_TCP, rand64());
        queue_frame(40, KIND_SWAPPED, 4'd5, PROTO_TCP, rand64());
        queue_frame(33, KIND_IPV4, 4'd5, PROTO_TCP, rand64());
        queue_frame(53, KIND_IPV4, 4'd5, PROTO_TCP, rand64());
        queue_frame(54, KIND_IPV4, 4'd5, PROTO_TCP, '1);
        queue_frame(41, KIND_IPV4, 4'd5, PROTO_UDP, rand64());
        queue_frame(42, KIND_IPV4, 4'd5, PROTO_UDP, 64'd0);
        queue_frame(45, KIND_IPV4, 4'd5, PROTO_SCTP, rand64());
        queue_frame(46, KIND_IPV4, 4'd5, PROTO_SCTP, rand64());
        queue_frame(60, KIND_IPV4, 4'd5, 8'd0, rand64());
        queue_frame(60, KIND_IPV4, 4'd5, 8'd255, rand64());
        queue_frame(34, KIND_IPV4, 4'd0, PROTO_UDP, rand64());
        queue_frame(34, KIND_IPV4, 4'd1, PROTO_TCP, rand64());
        queue_frame(93, KIND_IPV4, 4'd15, PROTO_TCP, rand64());
        queue_frame(94, KIND_IPV4, 4'd15, PROTO_TCP, rand64());
        queue_frame(20, KIND_IPV4, 4'd5, PROTO_UDP, rand64());
        wait_drained();

        // Back-pressure: short frames while the receiver holds off.
        for (int i = 0; i < 16; i++)
            queue_frame($urandom_range(1, 20), KIND_OTHER, 4'd5, PROTO_TCP, rand64());
        hold_request = 1'b1;
        wait_drained();

        // Random frames, mostly well-formed IPv4 close to the length thresholds.
        random_bytes = 0;
        while (random_bytes < RANDOM_ITEMS) begin
            pick  = $urandom_range(0, 99);
            ihl   = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15)) : 4'd5;
            case ($urandom_range(0, 9))
                0, 1, 2: proto = PROTO_TCP;
                3, 4, 5: proto = PROTO_UDP;
                6, 7, 8: proto = PROTO_SCTP;
                default: proto = 8'($urandom_range(0, 255));
            endcase
            if (proto == PROTO_UDP)
                hdr = UDP_HDR_LEN;
            else if (proto == PROTO_SCTP)
                hdr = SCTP_HDR_LEN;
            else
                hdr = TCP_HDR_LEN;
            need = ETH_HDR_LEN + 4 * ihl + hdr;
            if (pick < 70) begin
                kind = KIND_IPV4;
                len  = need + $urandom_range(0, 15) - 3;
                if (len < MIN_IPV4_FRAME && $urandom_range(0, 3) != 0)
                    len = MIN_IPV4_FRAME + $urandom_range(0, 4) - 1;
            end
            else if (pick < 85) begin
                kind = ($urandom_range(0, 3) == 0) ? KIND_SWAPPED : KIND_OTHER;
                len  = $urandom_range(10, 70);
            end
            else begin
                // Broken or truncated frames.
                kind = ($urandom_range(0, 1) == 0) ? KIND_IPV4 : KIND_OTHER;
                len  = $urandom_range(1, 36);
            end
            if (len < 1)
                len = 1;
            queue_frame(len, kind, ihl, proto, rand64());
            random_bytes += len;
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        fail_count += verdicts_due.size();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> ipv4_flow_header_parser.f
rtl/iffp_pkg.sv
rtl/iffp_front.sv
rtl/iffp_queue.sv
rtl/iffp_back.sv
rtl/ipv4_flow_header_parser.sv
tb/ipv4_flow_header_parser_tb.sv
